// File: rtl/phr_pkg.sv
// ----------------------------------------------------------------------------
// phr_pkg
// shared types and constants of the pixel hue rotation pipeline
// ----------------------------------------------------------------------------
package phr_pkg;

  // hue in degrees with 8 fraction bits
  localparam int unsigned DEG_FRAC   = 8;
  localparam int unsigned HUE_W      = 17;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned WGT_W      = 14;
  localparam int unsigned PROD_W     = 22;

  localparam logic [HUE_W-1:0] SIXTY_FX = HUE_W'(60 * 256);
  localparam logic [HUE_W-1:0] ONE20_FX = HUE_W'(120 * 256);
  localparam logic [HUE_W-1:0] ONE80_FX = HUE_W'(180 * 256);
  localparam logic [HUE_W-1:0] TWO40_FX = HUE_W'(240 * 256);
  localparam logic [HUE_W-1:0] THREE00_FX = HUE_W'(300 * 256);
  localparam logic [SUM_W-1:0] FULL_FX  = SUM_W'(360 * 256);
  localparam logic [SUM_W-1:0] TWO_FULL_FX = SUM_W'(720 * 256);

  // divider: 15 quotient bits, three per stage
  localparam int unsigned QBITS      = 15;
  localparam int unsigned DIV_BITS   = 3;
  localparam int unsigned DIV_STAGES = QBITS / DIV_BITS;
  localparam int unsigned NUM_W      = 23;

  // reciprocal of 15 for values below 4096, scaled by 2^16
  localparam logic [12:0] RECIP15    = 13'd4370;

  localparam logic [8:0]  SHIFT_RST  = 9'd180;

  // which channel is the minimum, sets the hue offset
  localparam logic [1:0] HB_BLUE_MIN  = 2'd0;
  localparam logic [1:0] HB_RED_MIN   = 2'd1;
  localparam logic [1:0] HB_GREEN_MIN = 2'd2;

  typedef enum logic [2:0] {
    SEC_0,
    SEC_1,
    SEC_2,
    SEC_3,
    SEC_4,
    SEC_5
  } sector_t;

  typedef struct packed {
    logic [7:0] mn;
    logic [7:0] delta;
    logic [1:0] hbase;
  } side_t;

endpackage

// File: rtl/phr_div.sv
// ----------------------------------------------------------------------------
// phr_div
// pipelined restoring divider, 15 * 1024 * num / den, three quotient bits
// per stage, with pixel sideband carried alongside
// ----------------------------------------------------------------------------
module phr_div (
  input  logic                            clk,
  input  logic [phr_pkg::DIV_STAGES-1:0]  en,
  input  logic [8:0]                      num,
  input  phr_pkg::side_t                  side_in,
  output logic [phr_pkg::QBITS-1:0]       quot,
  output phr_pkg::side_t                  side_out
);
  import phr_pkg::*;

  logic [NUM_W-1:0] num_fx;
  logic [12:0]      num15;

  logic [NUM_W-1:0] dnum [DIV_STAGES];
  logic [7:0]       drem [DIV_STAGES];
  logic [QBITS-1:0] dq   [DIV_STAGES];
  side_t            dside [DIV_STAGES];

  // numerator times 15360 as (n * 15) << 10
  assign num15  = {num, 4'b0} - {4'b0, num};
  assign num_fx = {num15, 10'b0};

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [NUM_W-1:0] n_in;
    logic [7:0]       r_in;
    logic [QBITS-1:0] q_in;
    side_t            s_in;
    logic [7:0]       r_out;
    logic [QBITS-1:0] q_out;

    if (k == 0) begin : g_first
      // top bits start the remainder, below the divisor whenever the divisor is nonzero
      assign n_in = num_fx;
      assign r_in = num_fx[NUM_W-1:QBITS];
      assign q_in = '0;
      assign s_in = side_in;
    end else begin : g_rest
      assign n_in = dnum[k-1];
      assign r_in = drem[k-1];
      assign q_in = dq[k-1];
      assign s_in = dside[k-1];
    end

    always_comb begin
      logic [8:0] trial;
      r_out = r_in;
      q_out = q_in;
      for (int j = 0; j < DIV_BITS; j++) begin
        trial = {r_out, n_in[QBITS - 1 - DIV_BITS * k - j]};
        if (trial >= {1'b0, s_in.delta}) begin
          trial = trial - {1'b0, s_in.delta};
          q_out[QBITS - 1 - DIV_BITS * k - j] = 1'b1;
        end
        r_out = trial[7:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        dnum[k]  <= n_in;
        drem[k]  <= r_out;
        dq[k]    <= q_out;
        dside[k] <= s_in;
      end
    end
  end

  assign quot     = dq[DIV_STAGES-1];
  assign side_out = dside[DIV_STAGES-1];

endmodule

// File: rtl/pixel_hue_rotate_core.sv
// ----------------------------------------------------------------------------
// pixel_hue_rotate_core
// rgb to hsv hue, add a programmable shift, back to rgb, and unless the output stalls, one pixel per clock
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  input     in_valid/in_ready, red_in/green_in/blue_in  request in
//  output    out_valid/out_ready, red_out/green_out/...  request out
//  config    hue_shift_we, hue_shift                     write only
//
//  eleven register stages; unless out_ready stalls the output, one pixel accepted per cycle
//  the five-stage hue divider sets the depth; each stage has a valid bit
//  and a local ready, so bubbles close up and a stall freezes only the
//  stages that are full behind a held result
//  rst is synchronous: clears valid bits and loads a shift of 180 degrees
// ----------------------------------------------------------------------------
module pixel_hue_rotate_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  input  logic       hue_shift_we,
  input  logic [8:0] hue_shift
);
  import phr_pkg::*;

  localparam int unsigned NST = DIV_STAGES + 6;

  // pipeline control
  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;

  // shift register
  logic [8:0] shift;

  // stage 0: min, max, delta and numerator
  side_t      s0_side;
  logic [8:0] s0_num;
  side_t      s0_side_next;
  logic [8:0] s0_num_next;

  // divider output
  logic [QBITS-1:0] div_q;
  side_t            div_side;

  // stage 6: rotated hue
  logic [HUE_W-1:0] s6_rot;
  side_t            s6_side;
  logic [HUE_W-1:0] s6_rot_next;

  // stage 7: sector and weight
  sector_t          s7_sector;
  logic [WGT_W-1:0] s7_w;
  side_t            s7_side;
  sector_t          s7_sector_next;
  logic [WGT_W-1:0] s7_w_next;

  // stage 8: delta times weight
  logic [PROD_W-1:0] s8_prod;
  sector_t           s8_sector;
  side_t             s8_side;

  // stage 9: intermediate value
  logic [7:0] s9_x;
  sector_t    s9_sector;
  side_t      s9_side;
  logic [7:0] s9_x_next;

  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;

  // ready ripples back from the output; a stage loads when empty or draining
  always_comb begin
    rdy[NST-1] = !vld[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift <= SHIFT_RST;
    end else if (hue_shift_we) begin
      shift <= hue_shift;
    end
  end

  // stage 0: blue wins ties for minimum, then red
  always_comb begin
    logic [7:0] mx;
    logic [7:0] mn;
    logic [7:0] dl;
    logic [9:0] acc;
    mx = (red_in > green_in) ? red_in : green_in;
    mx = (mx > blue_in) ? mx : blue_in;
    mn = (red_in < green_in) ? red_in : green_in;
    mn = (mn < blue_in) ? mn : blue_in;
    dl = mx - mn;
    if (mn == blue_in) begin
      acc = {2'b0, green_in} + {2'b0, dl} - {2'b0, red_in};
      s0_side_next.hbase = HB_BLUE_MIN;
    end else if (mn == red_in) begin
      acc = {2'b0, blue_in} + {2'b0, dl} - {2'b0, green_in};
      s0_side_next.hbase = HB_RED_MIN;
    end else begin
      acc = {2'b0, red_in} + {2'b0, dl} - {2'b0, blue_in};
      s0_side_next.hbase = HB_GREEN_MIN;
    end
    s0_side_next.mn    = mn;
    s0_side_next.delta = dl;
    s0_num_next        = acc[8:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_side <= s0_side_next;
      s0_num  <= s0_num_next;
    end
  end

  // stages 1..5: hue fraction within the sector pair
  phr_div u_div (
    .clk      (clk),
    .en       (rdy[DIV_STAGES:1]),
    .num      (s0_num),
    .side_in  (s0_side),
    .quot     (div_q),
    .side_out (div_side)
  );

  // stage 6: add sector offset and shift, wrap at 360 degrees
  always_comb begin
    logic [HUE_W-1:0] base;
    logic [HUE_W-1:0] hue;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wrapped;
    case (div_side.hbase)
      HB_BLUE_MIN:  base = '0;
      HB_RED_MIN:   base = ONE20_FX;
      HB_GREEN_MIN: base = TWO40_FX;
      default:      base = '0;
    endcase
    hue = {2'b0, div_q} + base;
    sum = {1'b0, hue} + {1'b0, shift, {DEG_FRAC{1'b0}}};
    if (sum >= TWO_FULL_FX) begin
      wrapped = sum - TWO_FULL_FX;
    end else if (sum >= FULL_FX) begin
      wrapped = sum - FULL_FX;
    end else begin
      wrapped = sum;
    end
    s6_rot_next = wrapped[HUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[DIV_STAGES+1]) begin
      s6_rot  <= s6_rot_next;
      s6_side <= div_side;
    end
  end

  // stage 7: sector and triangle weight 60 - |f - 60|
  always_comb begin
    logic [HUE_W-1:0] pair_base;
    logic [HUE_W-1:0] f;
    logic [HUE_W-1:0] tri_dist;
    logic [HUE_W-1:0] wgt;
    if (s6_rot < SIXTY_FX) begin
      s7_sector_next = SEC_0;
      pair_base      = '0;
    end else if (s6_rot < ONE20_FX) begin
      s7_sector_next = SEC_1;
      pair_base      = '0;
    end else if (s6_rot < ONE80_FX) begin
      s7_sector_next = SEC_2;
      pair_base      = ONE20_FX;
    end else if (s6_rot < TWO40_FX) begin
      s7_sector_next = SEC_3;
      pair_base      = ONE20_FX;
    end else if (s6_rot < THREE00_FX) begin
      s7_sector_next = SEC_4;
      pair_base      = TWO40_FX;
    end else begin
      s7_sector_next = SEC_5;
      pair_base      = TWO40_FX;
    end
    f        = s6_rot - pair_base;
    tri_dist = (f >= SIXTY_FX) ? (f - SIXTY_FX) : (SIXTY_FX - f);
    wgt      = SIXTY_FX - tri_dist;
    s7_w_next = wgt[WGT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[DIV_STAGES+2]) begin
      s7_sector <= s7_sector_next;
      s7_w      <= s7_w_next;
      s7_side   <= s6_side;
    end
  end

  // stage 8: chroma times weight
  always_ff @(posedge clk) begin
    if (rdy[DIV_STAGES+3]) begin
      s8_prod   <= PROD_W'(s7_side.delta) * PROD_W'(s7_w);
      s8_sector <= s7_sector;
      s8_side   <= s7_side;
    end
  end

  // stage 9: divide by 15360 as a shift by 10 then times 1/15
  always_comb begin
    logic [24:0] scaled;
    scaled    = 25'(s8_prod[PROD_W-1:10]) * 25'(RECIP15);
    s9_x_next = scaled[23:16];
  end

  always_ff @(posedge clk) begin
    if (rdy[DIV_STAGES+4]) begin
      s9_x      <= s9_x_next;
      s9_sector <= s8_sector;
      s9_side   <= s8_side;
    end
  end

  // stage 10: six-sector rebuild into the output register
  always_comb begin
    logic [7:0] mid;
    logic [7:0] mx;
    mid = s9_side.mn + s9_x;
    mx  = s9_side.mn + s9_side.delta;
    red_next   = s9_side.mn;
    green_next = s9_side.mn;
    blue_next  = s9_side.mn;
    case (s9_sector)
      SEC_0: begin
        red_next   = mx;
        green_next = mid;
      end
      SEC_1: begin
        red_next   = mid;
        green_next = mx;
      end
      SEC_2: begin
        green_next = mx;
        blue_next  = mid;
      end
      SEC_3: begin
        green_next = mid;
        blue_next  = mx;
      end
      SEC_4: begin
        red_next  = mid;
        blue_next = mx;
      end
      default: begin
        red_next  = mx;
        blue_next = mid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      red_out   <= red_next;
      green_out <= green_next;
      blue_out  <= blue_next;
    end
  end

endmodule

// File: tb/tb_pixel_hue_rotate_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_hue_rotate_core
// self-checking bench for the hue rotation pipeline
// ----------------------------------------------------------------------------
// pixels go in through a valid/ready request channel and come back the same
// way; a scoreboard predicts every rotated pixel in integer arithmetic and
// checks results in order. random gaps on the sender and random stalls on the
// receiver, hue shift reprogrammed between phases with the pipe drained
// ----------------------------------------------------------------------------
module tb_pixel_hue_rotate_core;
  import phr_pkg::*;

  localparam int PIPE_LAT     = 11;
  localparam int IDLE_LIMIT   = 1000;
  localparam int RAND_PIXELS  = 750;
  localparam int NUM_PHASES   = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // predicts rotated pixels and holds them until the block hands them back
  class hue_rotate_scoreboard;
    localparam int unsigned DEG60  = 60 * 256;
    localparam int unsigned DEG360 = 360 * 256;

    bit [8:0] shift;
    rgb_t     expected_q[$];
    int       errors;
    int       noted;
    int       checked;

    function new();
      shift = SHIFT_RST;
    endfunction

    function rgb_t rotate(rgb_t px);
      int unsigned r, g, b, mx, mn, delta, hue, rot, f, tri_dist, x, mid;
      sector_t sec;
      rgb_t res;
      r = px.red;
      g = px.green;
      b = px.blue;
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      delta = mx - mn;
      hue = 0;
      // blue wins a tie for minimum, then red
      if (delta != 0) begin
        if (mn == b) hue = (DEG60 * (g + delta - r)) / delta;
        else if (mn == r) hue = (DEG60 * (b + delta - g)) / delta + 2 * DEG60;
        else hue = (DEG60 * (r + delta - b)) / delta + 4 * DEG60;
      end
      rot = (hue + (32'(shift) << 8)) % DEG360;
      sec = sector_t'(rot / DEG60);
      f = rot % (2 * DEG60);
      tri_dist = (f >= DEG60) ? f - DEG60 : DEG60 - f;
      x = (delta * (DEG60 - tri_dist)) / DEG60;
      mid = mn + x;
      res = {8'(mn), 8'(mn), 8'(mn)};
      case (sec)
        SEC_0: begin res.red = 8'(mx); res.green = 8'(mid); end
        SEC_1: begin res.red = 8'(mid); res.green = 8'(mx); end
        SEC_2: begin res.green = 8'(mx); res.blue = 8'(mid); end
        SEC_3: begin res.green = 8'(mid); res.blue = 8'(mx); end
        SEC_4: begin res.red = 8'(mid); res.blue = 8'(mx); end
        default: begin res.red = 8'(mx); res.blue = 8'(mid); end
      endcase
      return res;
    endfunction

    function void note_pixel(rgb_t px);
      expected_q.push_back(rotate(px));
      noted++;
    endfunction

    function void check_pixel(rgb_t got);
      rgb_t want;
      if (expected_q.size() == 0) begin
        $error("result with no pixel pending: %0d %0d %0d", got.red, got.green, got.blue);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.red !== want.red) begin
        $error("red_out mismatch: expected %0d, got %0d", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("green_out mismatch: expected %0d, got %0d", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("blue_out mismatch: expected %0d, got %0d", want.blue, got.blue);
        errors++;
      end
    endfunction

    function void close_out();
      if (expected_q.size() != 0) begin
        $error("%0d rotated pixels never came out", expected_q.size());
        errors += expected_q.size();
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] red_in = '0;
  logic [7:0] green_in = '0;
  logic [7:0] blue_in = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       hue_shift_we = 1'b0;
  logic [8:0] hue_shift = '0;

  hue_rotate_scoreboard sb = new();
  int shift_settings = 1;  // reset value counts as the first

  pixel_hue_rotate_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .hue_shift_we (hue_shift_we),
    .hue_shift    (hue_shift)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sender gap: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // receiver stall, same shape but fewer zero-length ones
  function automatic int pick_stall();
    int p;
    p = $urandom_range(0, 99);
    if (p < 30) return 0;
    if (p < 80) return $urandom_range(1, 3);
    if (p < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random pixel, biased toward gray, ties, extremes and tiny chroma
  function automatic rgb_t rand_pixel();
    int kind;
    logic [7:0] a, b, c;
    logic [7:0] ends [4];
    kind = $urandom_range(0, 99);
    a = 8'($urandom);
    b = 8'($urandom);
    c = 8'($urandom);
    ends = '{8'h00, 8'h01, 8'hfe, 8'hff};
    if (kind < 10) return {a, a, a};
    if (kind < 25) begin
      case ($urandom_range(0, 2))
        0: return {a, a, b};
        1: return {a, b, a};
        default: return {b, a, a};
      endcase
    end
    if (kind < 35)
      return {ends[$urandom_range(0, 3)], ends[$urandom_range(0, 3)],
              ends[$urandom_range(0, 3)]};
    if (kind < 45)
      return {a, 8'(a + $urandom_range(0, 2)), 8'(a + $urandom_range(0, 2))};
    return {a, b, c};
  endfunction

  // one pixel request; valid is only lowered when a gap is wanted
  task automatic send_pixel(input rgb_t px, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in   <= px.red;
    green_in <= px.green;
    blue_in  <= px.blue;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(px);
  endtask

  // hold the sender until every pending result is back, then let the pipe settle
  task automatic drain_pipe();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_shift(input logic [8:0] value);
    hue_shift_we <= 1'b1;
    hue_shift    <= value;
    @(posedge clk);
    hue_shift_we <= 1'b0;
    sb.shift = value;
    shift_settings++;
  endtask

  // receiver: check every accepted result, then pick the next ready level
  int ready_run = 0;
  int stall_run = 0;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_pixel({red_out, green_out, blue_out});
    if (ready_run == 0 && stall_run == 0) begin
      // now and then a long stretch with no stalls at all
      ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                             : $urandom_range(1, 20);
      stall_run = pick_stall();
    end
    if (ready_run > 0) begin
      out_ready <= 1'b1;
      ready_run--;
    end else begin
      out_ready <= 1'b0;
      stall_run--;
    end
  end

  // watchdog on cycles where neither request side moves
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request accepted for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // gray levels, primaries, ties for minimum, unit chroma, one per sector
  rgb_t corner_px [] = '{
    24'h000000, 24'hffffff, 24'h808080,
    24'hff0000, 24'h00ff00, 24'h0000ff,
    24'hffff00, 24'h00ffff, 24'hff00ff,
    24'h010000, 24'h000001, 24'hfffe00,
    24'hc86432, 24'h32c864, 24'h6432c8,
    24'h0001ff, 24'hff0001, 24'hff8000,
    24'h01fe80, 24'hfe0180, 24'h7f0080
  };

  // shift per random phase: both ends, the wrap point and beyond, sector edges
  logic [8:0] phase_shift [NUM_PHASES] = '{
    9'd0, 9'd511, 9'd359, 9'd360, 9'd1, 9'd60, 9'd300, 9'd256, 9'd0, 9'd0
  };

  initial begin
    int per_phase;
    bit back_to_back;
    per_phase = RAND_PIXELS / NUM_PHASES;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed pixels at the reset shift, sent back to back
    foreach (corner_px[i]) send_pixel(corner_px[i], 0);
    drain_pipe();

    phase_shift[8] = 9'($urandom_range(0, 511));
    phase_shift[9] = 9'($urandom_range(0, 359));
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_shift(phase_shift[ph]);
      // some phases run with the sender never idling
      back_to_back = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < per_phase; n++)
        send_pixel(rand_pixel(), back_to_back ? 0 : pick_gap());
      drain_pipe();
    end

    sb.close_out();
    $display("run covered %0d pixels over %0d hue shift settings", sb.noted, shift_settings);
    $display("%0d rotated pixels checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/phr_pkg.sv
rtl/phr_div.sv
rtl/pixel_hue_rotate_core.sv
tb/tb_pixel_hue_rotate_core.sv
